@@ rtl/core/isa_pkg.sv @@
// ----------------------------------------------------------------------------
// isa_pkg
// Shared types and constants for the indexed shift array: capacity, derived
// widths, request and status codes, controller states and command bundle.
// ----------------------------------------------------------------------------
package isa_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 5;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [2:0] {
        ACT_APPEND = 3'd0,
        ACT_DROP   = 3'd1,
        ACT_INSERT = 3'd2,
        ACT_REMOVE = 3'd3,
        ACT_CLEAR  = 3'd4,
        ACT_READ   = 3'd5,
        ACT_WRITE  = 3'd6
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic load;   // capture request fields
        logic exec;   // apply request, load result register
    } t_dp_cmd;

endpackage

@@ rtl/core/isa_ctrl.sv @@
// ----------------------------------------------------------------------------
// isa_ctrl
// Controller: handshake on both channels, two-state sequencer, result valid.
// ----------------------------------------------------------------------------
module isa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output isa_pkg::t_dp_cmd o_cmd
);

    isa_pkg::t_state r_state;
    isa_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            slot_free;

    // result register can take a new transaction this cycle
    assign slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            isa_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = isa_pkg::S_EXEC;
                end
            end
            isa_pkg::S_EXEC: begin
                if (slot_free) begin
                    n_state = isa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = isa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            isa_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            isa_pkg::S_EXEC: begin
                o_cmd.exec = slot_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= isa_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/core/isa_dpath.sv @@
// ----------------------------------------------------------------------------
// isa_dpath
// Datapath: request register, row of entry cells with up/down shift, fill
// count and result register.
// ----------------------------------------------------------------------------
module isa_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  isa_pkg::t_dp_cmd   i_cmd,
    input  logic [2:0]         i_action,
    input  logic [4:0]         i_position,
    input  logic signed [31:0] i_value_in,
    output logic signed [31:0] o_read_value,
    output logic [4:0]         o_fill_count,
    output logic               o_is_empty,
    output logic [1:0]         o_status
);

    logic [2:0]                    r_action;
    logic [isa_pkg::POS_W-1:0]     r_pos;
    logic signed [31:0]            r_word;
    logic signed [31:0]            r_ent [isa_pkg::CAPACITY];
    logic signed [31:0]            n_ent [isa_pkg::CAPACITY];
    logic signed [31:0]            up    [isa_pkg::CAPACITY];
    logic signed [31:0]            dn    [isa_pkg::CAPACITY];
    logic [isa_pkg::CNT_W-1:0]     r_count;
    logic [isa_pkg::CNT_W-1:0]     n_count;
    logic signed [31:0]            r_rd;
    logic signed [31:0]            n_rd;
    isa_pkg::t_status              r_st;
    isa_pkg::t_status              n_st;
    logic [isa_pkg::CMP_W-1:0]     pos_c;
    logic [isa_pkg::CMP_W-1:0]     cnt_c;
    logic [isa_pkg::CMP_W-1:0]     ins_at;
    logic                          full;
    logic                          do_ins;
    logic                          do_rem;
    logic                          do_wr;

    assign pos_c = isa_pkg::CMP_W'(r_pos);
    assign cnt_c = isa_pkg::CMP_W'(r_count);
    assign full  = (r_count == isa_pkg::CNT_W'(isa_pkg::CAPACITY));

    // request decode
    always_comb begin
        do_ins  = 1'b0;
        do_rem  = 1'b0;
        do_wr   = 1'b0;
        ins_at  = cnt_c;
        n_count = r_count;
        n_st    = isa_pkg::ST_DONE;
        n_rd    = '0;
        case (isa_pkg::t_action'(r_action))
            isa_pkg::ACT_APPEND: begin
                if (full) begin
                    n_st = isa_pkg::ST_FULL;
                end else begin
                    do_ins  = 1'b1;
                    n_count = r_count + isa_pkg::CNT_W'(1);
                end
            end
            isa_pkg::ACT_DROP: begin
                if (r_count == '0) begin
                    n_st = isa_pkg::ST_IGNORED;
                end else begin
                    n_count = r_count - isa_pkg::CNT_W'(1);
                end
            end
            isa_pkg::ACT_INSERT: begin
                if (pos_c > cnt_c) begin
                    n_st = isa_pkg::ST_IGNORED;
                end else if (full) begin
                    n_st = isa_pkg::ST_FULL;
                end else begin
                    do_ins  = 1'b1;
                    ins_at  = pos_c;
                    n_count = r_count + isa_pkg::CNT_W'(1);
                end
            end
            isa_pkg::ACT_REMOVE: begin
                if (pos_c >= cnt_c) begin
                    n_st = isa_pkg::ST_IGNORED;
                end else begin
                    do_rem  = 1'b1;
                    n_count = r_count - isa_pkg::CNT_W'(1);
                end
            end
            isa_pkg::ACT_CLEAR: begin
                n_count = '0;
            end
            isa_pkg::ACT_READ: begin
                if (pos_c >= cnt_c) begin
                    n_st = isa_pkg::ST_IGNORED;
                end else begin
                    n_rd = r_ent[isa_pkg::IDX_W'(r_pos)];
                end
            end
            isa_pkg::ACT_WRITE: begin
                if (pos_c >= cnt_c) begin
                    n_st = isa_pkg::ST_IGNORED;
                end else begin
                    do_wr = 1'b1;
                end
            end
            default: begin
                n_st = isa_pkg::ST_IGNORED;
            end
        endcase
    end

    // neighbor taps for the shift
    always_comb begin
        up[0] = r_word;
        for (int k = 1; k < isa_pkg::CAPACITY; k++) begin
            up[k] = r_ent[k-1];
        end
        for (int k = 0; k < isa_pkg::CAPACITY - 1; k++) begin
            dn[k] = r_ent[k+1];
        end
        dn[isa_pkg::CAPACITY-1] = r_ent[isa_pkg::CAPACITY-1];
    end

    // per-cell next value
    always_comb begin
        for (int k = 0; k < isa_pkg::CAPACITY; k++) begin
            n_ent[k] = r_ent[k];
            if (do_ins && (isa_pkg::CMP_W'(k) == ins_at)) begin
                n_ent[k] = r_word;
            end else if (do_ins && (isa_pkg::CMP_W'(k) > ins_at)) begin
                n_ent[k] = up[k];
            end
            if (do_rem && (isa_pkg::CMP_W'(k) >= pos_c)) begin
                n_ent[k] = dn[k];
            end
            if (do_wr && (isa_pkg::CMP_W'(k) == pos_c)) begin
                n_ent[k] = r_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_pos    <= i_position;
            r_word   <= i_value_in;
        end
        if (i_cmd.exec) begin
            r_ent <= n_ent;
            r_rd  <= n_rd;
            r_st  <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    assign o_read_value = r_rd;
    assign o_fill_count = 5'(r_count);
    assign o_is_empty   = (r_count == '0);
    assign o_status     = r_st;

endmodule

@@ rtl/core/indexed_shift_array.sv @@
// ----------------------------------------------------------------------------
// indexed_shift_array
// Ordered array of signed 32-bit words with append, drop, insert, remove,
// clear, read and write requests; one result per request.
// ----------------------------------------------------------------------------
// Each transaction first captures the request, then executes: in that step
// the whole row of entry cells shifts up, shifts down or is written in
// parallel and the result register is loaded. The next request is taken right
// after, while the previous result may still sit in the output register; a
// stalled output holds the block in its execute state until the register
// frees up. Every result carries the fill count after the request and an
// empty flag. Status reads done, ignored (index out of range, drop on an
// empty array, or an undefined action code) or full (append or insert with
// no room; an insert past the end reports ignored first). read_value is zero
// except for a successful read. Clear only resets the count. No clearing pass
// is needed after reset.
// ----------------------------------------------------------------------------
module indexed_shift_array (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_action,
    input  logic [4:0]         i_position,
    input  logic signed [31:0] i_value_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_read_value,
    output logic [4:0]         o_fill_count,
    output logic               o_is_empty,
    output logic [1:0]         o_status
);

    isa_pkg::t_dp_cmd cmd;

    // sequencer and handshake
    isa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // entry cells, count and result register
    isa_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_action     (i_action),
        .i_position   (i_position),
        .i_value_in   (i_value_in),
        .o_read_value (o_read_value),
        .o_fill_count (o_fill_count),
        .o_is_empty   (o_is_empty),
        .o_status     (o_status)
    );

endmodule

@@ rtl/core/isa_checker.sv @@
// ----------------------------------------------------------------------------
// isa_checker
// Port-level checks for the indexed shift array, bound to the top level.
// ----------------------------------------------------------------------------
module isa_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [31:0] o_read_value,
    input logic [4:0]         o_fill_count,
    input logic               o_is_empty,
    input logic [1:0]         o_status
);

    // empty flag tracks the count
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_empty == (o_fill_count == 5'd0)))
        else $error("is_empty disagrees with fill_count");

    // count never passes capacity
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_fill_count) <= isa_pkg::CAPACITY))
        else $error("fill_count above capacity");

    // one transaction in flight: busy right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second transaction taken while busy");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_read_value) && $stable(o_fill_count)
             && $stable(o_status)))
        else $error("stalled result changed");

endmodule

bind indexed_shift_array isa_checker u_isa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_read_value (o_read_value),
    .o_fill_count (o_fill_count),
    .o_is_empty   (o_is_empty),
    .o_status     (o_status)
);
